// ===== rtl/core/isb_pkg.sv =====
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types, sizes and codes of the indexed stack buffer.
// ----------------------------------------------------------------------------
package isb_pkg;

   // Storage geometry
   localparam int DEPTH         = 64;
   localparam int ELEMENT_WIDTH = 32;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = $clog2(DEPTH + 1);

   // Stream field widths
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int FOUND_W  = 7;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Signed width wide enough for position, count and their sum
   localparam int RES_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET    = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   localparam logic signed [FOUND_W-1:0] NOT_FOUND = -7'sd1;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [POS_W-1:0]  position;
      logic [VALUE_W-1:0]       element_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]        read_value;
      logic signed [FOUND_W-1:0] found_position;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // Port A write, port B read of the element memory
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic [ELEMENT_WIDTH-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } ram_ctrl_type;

endpackage

// ===== rtl/core/isb_ram.sv =====
// ----------------------------------------------------------------------------
// isb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module isb_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/isb_engine.sv =====
// ----------------------------------------------------------------------------
// isb_engine
// Operation sequencer: resolves positions, keeps the entry count, reads
// the element memory for get and pop and walks it for remove and find.
// ----------------------------------------------------------------------------
module isb_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  isb_pkg::req_type                  req,
   output isb_pkg::ram_ctrl_type             ram_ctrl,
   input  logic [isb_pkg::ELEMENT_WIDTH-1:0] ram_rd_data,
   output logic                              res_valid,
   input  logic                              res_take,
   output isb_pkg::rsp_type                  res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT,
      S_SCAN,
      S_RESULT
   } state_type;

   localparam int CNT_W = isb_pkg::CNT_W;
   localparam int IDX_W = isb_pkg::IDX_W;
   localparam int EW    = isb_pkg::ELEMENT_WIDTH;
   localparam int RES_W = isb_pkg::RES_W;

   state_type                              state_ff, state_in;
   logic [CNT_W-1:0]                       count_ff, count_in;
   logic [CNT_W-1:0]                       cur_ff, cur_in;
   logic [EW-1:0]                          val_ff, val_in;
   logic [isb_pkg::VALUE_W-1:0]            rd_ff, rd_in;
   logic signed [isb_pkg::FOUND_W-1:0]     found_ff, found_in;
   logic [isb_pkg::STATUS_W-1:0]           status_ff, status_in;

   logic signed [RES_W-1:0] pos_ext;
   logic signed [RES_W-1:0] cnt_ext;
   logic signed [RES_W-1:0] back_sum;
   logic                    out_of_range;
   logic [IDX_W-1:0]        idx;
   logic [CNT_W-1:0]        idx_next;
   logic [CNT_W-1:0]        cur_next;

   // Resolve a signed position against the current count
   always_comb begin
      pos_ext  = RES_W'(req.position);
      cnt_ext  = signed'(RES_W'(count_ff));
      back_sum = cnt_ext + pos_ext;
      if (pos_ext < 0) begin
         out_of_range = back_sum < 0;
         idx          = back_sum[IDX_W-1:0];
      end else begin
         out_of_range = pos_ext >= cnt_ext;
         idx          = pos_ext[IDX_W-1:0];
      end
      idx_next = CNT_W'(idx) + CNT_W'(1);
      cur_next = cur_ff + CNT_W'(1);
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      val_in    = val_ff;
      rd_in     = rd_ff;
      found_in  = found_ff;
      status_in = status_ff;
      ram_ctrl  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in    = EW'(req.element_value);
               rd_in     = '0;
               found_in  = '0;
               status_in = isb_pkg::ST_OK;
               state_in  = S_RESULT;
               case (req.operation)
                  isb_pkg::OP_PUSH: begin
                     if (count_ff == CNT_W'(isb_pkg::DEPTH)) begin
                        status_in = isb_pkg::ST_FULL;
                     end else begin
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = count_ff[IDX_W-1:0];
                        ram_ctrl.wr_data = EW'(req.element_value);
                        count_in         = count_ff + CNT_W'(1);
                     end
                  end
                  isb_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = isb_pkg::ST_EMPTY;
                     end else begin
                        count_in         = count_ff - CNT_W'(1);
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = count_in[IDX_W-1:0];
                        state_in         = S_READ;
                     end
                  end
                  isb_pkg::OP_GET: begin
                     if (out_of_range) begin
                        status_in = isb_pkg::ST_RANGE;
                     end else begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = idx;
                        state_in         = S_READ;
                     end
                  end
                  isb_pkg::OP_SET: begin
                     if (out_of_range) begin
                        status_in = isb_pkg::ST_RANGE;
                     end else begin
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = idx;
                        ram_ctrl.wr_data = EW'(req.element_value);
                     end
                  end
                  isb_pkg::OP_REMOVE: begin
                     if (out_of_range) begin
                        status_in = isb_pkg::ST_RANGE;
                     end else if (idx_next < count_ff) begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = idx_next[IDX_W-1:0];
                        cur_in           = idx_next;
                        state_in         = S_SHIFT;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  isb_pkg::OP_FIND: begin
                     found_in = isb_pkg::NOT_FOUND;
                     if (count_ff != '0) begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = '0;
                        cur_in           = '0;
                        state_in         = S_SCAN;
                     end
                  end
                  isb_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rd_in    = isb_pkg::VALUE_W'(ram_rd_data);
            state_in = S_RESULT;
         end
         S_SHIFT: begin
            // move the entry read last cycle down one place
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = IDX_W'(cur_ff - CNT_W'(1));
            ram_ctrl.wr_data = ram_rd_data;
            if (cur_next < count_ff) begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = cur_next[IDX_W-1:0];
               cur_in           = cur_next;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            if (ram_rd_data == val_ff) begin
               found_in = isb_pkg::FOUND_W'(cur_ff);
               state_in = S_RESULT;
            end else if (cur_next < count_ff) begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = cur_next[IDX_W-1:0];
               cur_in           = cur_next;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cur_ff    <= cur_in;
      val_ff    <= val_in;
      rd_ff     <= rd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_RESULT;

   always_comb begin
      res.read_value     = rd_ff;
      res.found_position = found_ff;
      res.status         = status_ff;
      res.count          = isb_pkg::COUNT_W'(count_ff);
   end

endmodule

// ===== rtl/core/indexed_stack_buffer.sv =====
// ----------------------------------------------------------------------------
// indexed_stack_buffer
// Bounded list store with push, pop, get, set, remove, find and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transaction: req_tuser holds the code,
//   req_tdata the position (negative counts back from the end) and value.
//   rsp_* returns exactly one result per request: read value, found index,
//   status and the entry count after the operation.
//   One request is in work at a time. Push, set, clear, errors and find on
//   an empty list go straight to the result; get and pop read one entry
//   first; remove shifts each entry behind the removed one down one place;
//   find reads entries from index 0 until a match or the end of the list.
//   The next request is taken in the cycle after the result moves into the
//   output register; remove and find walk the element memory one entry per
//   cycle.
//   Reset empties the list at once (no clearing pass); entries hold stale
//   data until written again. When the receiver stalls, the result waits in
//   the output register and the engine holds its own result behind it.
// ----------------------------------------------------------------------------
module indexed_stack_buffer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [isb_pkg::REQ_TDATA_W-1:0] req_tdata,  // position[6:0], element_value[38:7], zero pad
   input  logic [isb_pkg::OP_W-1:0]        req_tuser,  // operation[2:0]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [isb_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // read_value[31:0], found_position[38:32],
                                                       // count[45:39], zero pad
   output logic [isb_pkg::STATUS_W-1:0]    rsp_tuser   // status[1:0]
);

   localparam int P_W = isb_pkg::POS_W;
   localparam int V_W = isb_pkg::VALUE_W;

   isb_pkg::req_type                  req;
   isb_pkg::ram_ctrl_type             ram_ctrl;
   logic [isb_pkg::ELEMENT_WIDTH-1:0] ram_rd_data;
   logic                              res_valid;
   logic                              res_take;
   isb_pkg::rsp_type                  res;

   logic                              rsp_valid_ff, rsp_valid_in;
   isb_pkg::rsp_type                  rsp_ff, rsp_in;

   // unpack the request transaction
   always_comb begin
      req.operation     = req_tuser;
      req.position      = signed'(req_tdata[P_W-1:0]);
      req.element_value = req_tdata[P_W+V_W-1:P_W];
   end

   isb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .ram_ctrl    (ram_ctrl),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   isb_ram #(
      .WIDTH (isb_pkg::ELEMENT_WIDTH),
      .DEPTH (isb_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_ctrl.wr_en),
      .wr_addr (ram_ctrl.wr_addr),
      .wr_data (ram_ctrl.wr_data),
      .rd_en   (ram_ctrl.rd_en),
      .rd_addr (ram_ctrl.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: load when empty or draining, otherwise hold
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.count, rsp_ff.found_position, rsp_ff.read_value};
   assign rsp_tuser  = rsp_ff.status;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // one request at a time: the engine is busy right after acceptance
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready
   ) else $error("request accepted while engine busy");

   // a full report must come with a full count
   a_full_count: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status == isb_pkg::ST_FULL)
         |-> (rsp_ff.count == isb_pkg::COUNT_W'(isb_pkg::DEPTH))
   ) else $error("full status with count below depth");

   // an empty report must come with a zero count
   a_empty_count: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status == isb_pkg::ST_EMPTY) |-> (rsp_ff.count == '0)
   ) else $error("empty status with nonzero count");

   // a range error returns no data
   a_range_clean: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.status == isb_pkg::ST_RANGE)
         |-> (rsp_ff.read_value == '0 && rsp_ff.found_position == '0)
   ) else $error("range error with data");

endmodule

// ===== verif/isb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isb_checker
// Watches both stream channels of the indexed stack buffer, keeps a shadow
// copy of the list, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module isb_checker
   import isb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]    rsp_tuser,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count,
   output int                     full_count,
   output int                     empty_count,
   output int                     range_count,
   output int                     hit_count
);

   logic [ELEMENT_WIDTH-1:0] list_mem [DEPTH];
   int                       list_len;
   rsp_type                  expected_rsp_q [$];
   int                       n_fail, n_checked, n_full, n_empty, n_range, n_hit;

   assign fail_count    = n_fail;
   assign checked_count = n_checked;
   assign full_count    = n_full;
   assign empty_count   = n_empty;
   assign range_count   = n_range;
   assign hit_count     = n_hit;

   // Map a signed position onto a slot of the shadow list, -1 if outside it.
   function automatic int resolve_slot(logic signed [POS_W-1:0] pos);
      int p;
      p = pos;
      if (p < 0) begin
         if (-p > list_len) return -1;
         return list_len + p;
      end
      if (p >= list_len) return -1;
      return p;
   endfunction

   // Apply one request to the shadow list and return the response it owes.
   function automatic rsp_type apply_list_op(req_type rq);
      rsp_type                  r;
      int                       slot;
      logic [ELEMENT_WIDTH-1:0] val;
      r    = '0;
      val  = rq.element_value[ELEMENT_WIDTH-1:0];
      slot = resolve_slot(rq.position);
      case (rq.operation)
         OP_PUSH: begin
            if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         OP_POP: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               list_len--;
               r.read_value = list_mem[list_len];
            end
         end
         OP_GET: begin
            if (slot < 0) r.status = ST_RANGE;
            else r.read_value = list_mem[slot];
         end
         OP_SET: begin
            if (slot < 0) r.status = ST_RANGE;
            else list_mem[slot] = val;
         end
         OP_REMOVE: begin
            if (slot < 0) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
               list_len--;
            end
         end
         OP_FIND: begin
            r.found_position = NOT_FOUND;
            for (int i = 0; i < list_len; i++) begin
               if (list_mem[i] == val) begin
                  r.found_position = FOUND_W'(i);
                  break;
               end
            end
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      r.count = COUNT_W'(list_len);
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      req_type rq;
      rsp_type got, want;
      if (reset) begin
         list_len = 0;
         expected_rsp_q.delete();
      end else begin
         // Retire the response first: it always belongs to an older request.
         if (rsp_tvalid && rsp_tready) begin
            got.read_value     = rsp_tdata[VALUE_W-1:0];
            got.found_position = rsp_tdata[VALUE_W +: FOUND_W];
            got.count          = rsp_tdata[VALUE_W + FOUND_W +: COUNT_W];
            got.status         = rsp_tuser;
            if (expected_rsp_q.size() == 0) begin
               $error("response transaction with no request waiting");
               n_fail++;
            end else begin
               want = expected_rsp_q.pop_front();
               n_checked++;
               check_field("read_value", want.read_value, got.read_value);
               check_field("found_position", want.found_position, got.found_position);
               check_field("status", want.status, got.status);
               check_field("count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready) begin
            rq.operation     = req_tuser;
            rq.position      = req_tdata[POS_W-1:0];
            rq.element_value = req_tdata[POS_W +: VALUE_W];
            want = apply_list_op(rq);
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_EMPTY) n_empty++;
            if (want.status == ST_RANGE) n_range++;
            if (rq.operation == OP_FIND && want.found_position != NOT_FOUND) n_hit++;
            expected_rsp_q.push_back(want);
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the indexed stack buffer: a directed opening,
// a fill to full, then random phases of list operations with bursty
// requests and a stalling receiver; the checker compares every response.
// ----------------------------------------------------------------------------
module tb;
   import isb_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   localparam int POOL_SIZE    = 8;

   // Operation code that the block must treat as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} op_mix_e;
   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SKIP, READY_TRICKLE} ready_mode_e;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // position[6:0], element_value[38:7], zero pad
   logic [OP_W-1:0]        req_tuser  = OP_PUSH;  // operation[2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata; // read_value[31:0], found_position[38:32], count[45:39]
   logic [STATUS_W-1:0]    rsp_tuser;  // status[1:0]

   int fail_count, pending_count, checked_count;
   int full_count, empty_count, range_count, hit_count;

   int burst_left  = 0;
   int items_sent  = 0;
   int cycle_count = 0;
   logic [VALUE_W-1:0] value_pool [POOL_SIZE];

   ready_mode_e ready_mode  = READY_ALWAYS;
   int          ready_hold  = 0;
   int          ready_tick  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   indexed_stack_buffer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   isb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_count    (full_count),
      .empty_count   (empty_count),
      .range_count   (range_count),
      .hit_count     (hit_count)
   );

   // Receiver: switch between stall patterns after a random hold, so
   // some stretches accept every response and others hold them for long.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_hold == 0) begin
         ready_mode <= ready_mode_e'($urandom_range(0, 3));
         ready_hold <= $urandom_range(100, 400);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         READY_SKIP:   rsp_tready <= (ready_tick % 5) != 0;
         default:      rsp_tready <= (ready_tick % 16) < 4;
      endcase
   end

   // Watchdog: end the run if it hangs anywhere.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses checked", cycle_count, checked_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Send one request transaction. Open a new burst with a random gap in
   // front of it when the current burst is used up; keep tvalid high
   // between back-to-back transactions of a burst.
   task automatic issue(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                        input logic [VALUE_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, val, pos};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Hold off the sender until every outstanding response has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // Mostly small positions so that many land inside the list, plus the
   // extremes and fully random bit patterns.
   function automatic logic signed [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return POS_W'(int'($urandom_range(0, 40)) - 20);
      if (r == 6) return ($urandom_range(0, 1) != 0) ? 7'sd63 : -7'sd64;
      return POS_W'($urandom());
   endfunction

   // Draw values from a small pool often enough that find hits, and refresh
   // the pool with fresh random values that get stored.
   function automatic logic [VALUE_W-1:0] pick_value(input logic [OP_W-1:0] op);
      logic [VALUE_W-1:0] v;
      if ($urandom_range(0, 1) == 0 || (op == OP_FIND && $urandom_range(0, 2) != 0)) begin
         v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         v = $urandom();
         if (op == OP_PUSH || op == OP_SET) value_pool[$urandom_range(2, POOL_SIZE - 1)] = v;
      end
      return v;
   endfunction

   // Weight the operations by phase: fill toward full, churn in the middle,
   // drain toward empty, or throw in anything including the unused code.
   function automatic logic [OP_W-1:0] pick_operation(input op_mix_e mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 65) return OP_PUSH;
            if (r < 73) return OP_GET;
            if (r < 80) return OP_SET;
            if (r < 89) return OP_FIND;
            if (r < 95) return OP_REMOVE;
            return OP_POP;
         end
         MIX_CHURN: begin
            if (r < 25) return OP_PUSH;
            if (r < 37) return OP_POP;
            if (r < 51) return OP_GET;
            if (r < 63) return OP_SET;
            if (r < 76) return OP_REMOVE;
            if (r < 97) return OP_FIND;
            if (r < 99) return OP_CLEAR;
            return OP_UNUSED;
         end
         MIX_DRAIN: begin
            if (r < 12) return OP_PUSH;
            if (r < 42) return OP_POP;
            if (r < 52) return OP_GET;
            if (r < 58) return OP_SET;
            if (r < 82) return OP_REMOVE;
            if (r < 98) return OP_FIND;
            return OP_CLEAR;
         end
         default: return OP_W'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      op_mix_e          mix;
      int               phase_len;
      int               random_start;
      logic [OP_W-1:0]  op;

      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: the empty list first, then a short list of four.
      issue(OP_POP,    0,  $urandom());      // pop when empty
      issue(OP_GET,    0,  $urandom());      // any index on an empty list
      issue(OP_FIND,   0,  32'h0000_0005);   // find on an empty list
      issue(OP_REMOVE, -1, $urandom());
      issue(OP_PUSH,   0,  32'h0000_0000);
      issue(OP_PUSH,   0,  32'hFFFF_FFFF);
      issue(OP_PUSH,   0,  32'hA5A5_A5A5);
      issue(OP_PUSH,   0,  32'h1234_5678);
      issue(OP_GET,    0,  $urandom());
      issue(OP_GET,    -1, $urandom());      // last entry
      issue(OP_GET,    -4, $urandom());      // first entry, counted from the end
      issue(OP_GET,    -5, $urandom());      // just past the front
      issue(OP_GET,    4,  $urandom());      // just past the end
      issue(OP_SET,    -2, 32'h5A5A_5A5A);
      issue(OP_FIND,   0,  32'hFFFF_FFFF);   // hit in the middle
      issue(OP_FIND,   0,  32'h0000_0077);   // miss
      issue(OP_REMOVE, 0,  $urandom());      // shift the whole list down
      issue(OP_GET,    0,  $urandom());
      issue(OP_UNUSED, 0,  $urandom());      // no-op code
      issue(OP_GET,    63, $urandom());
      issue(OP_SET,    -64, 32'hFFFF_FFFF);
      issue(OP_POP,    0,  $urandom());
      issue(OP_REMOVE, -1, $urandom());
      issue(OP_CLEAR,  0,  $urandom());
      issue(OP_PUSH,   63, 32'h8000_0001);
      wait_drained();

      // Fill past full so that the full flag and the deepest walks show up.
      random_start = items_sent;
      issue(OP_CLEAR, 0, $urandom());
      repeat (DEPTH + 6) issue(OP_PUSH, pick_position(), pick_value(OP_PUSH));
      issue(OP_FIND, 0, $urandom());

      // Random phases; drain the pipeline now and then between them.
      while (items_sent - random_start < RANDOM_ITEMS) begin
         mix       = op_mix_e'($urandom_range(0, 3));
         phase_len = $urandom_range(30, 90);
         repeat (phase_len) begin
            op = pick_operation(mix);
            issue(op, pick_position(), pick_value(op));
         end
         if ($urandom_range(0, 2) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked in %0d cycles",
               items_sent, checked_count, cycle_count);
      $display("full pushes %0d, empty pops %0d, range errors %0d, find hits %0d",
               full_count, empty_count, range_count, hit_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== indexed_stack_buffer.f =====
rtl/core/isb_pkg.sv
rtl/core/isb_ram.sv
rtl/core/isb_engine.sv
rtl/core/indexed_stack_buffer.sv
verif/isb_checker.sv
verif/tb.sv
